// ===== sv/afr_pkg.sv =====
// shared constants, tables and types of the allpass and delay network reverb
package afr_pkg;

	localparam int AP_MAX_DELAY_DEF   = 4096;
	localparam int FDN_MAX_DELAY_DEF  = 32768;
	localparam int ALLPASS_STAGES_DEF = 4;
	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int NET_LINES          = 4;
	localparam int IDX_BITS           = 3;

	localparam logic [9:0]  AP_TABLE   [4] = '{10'd225, 10'd556, 10'd441, 10'd341};
	localparam logic [12:0] NET_TABLE  [4] = '{13'd3771, 13'd4587, 13'd5297, 13'd6121};
	localparam logic [15:0] GAIN_TABLE [8] = '{16'd16384, 16'd19661, 16'd22938, 16'd26214,
		16'd29491, 16'd32768, 16'd36045, 16'd39322};

	localparam logic [15:0] ROOM_MIN  = 16'd3277;
	localparam logic [15:0] ROOM_MAX  = 16'd32768;
	localparam logic [14:0] DAMP_MAX  = 15'd32440;
	localparam logic [15:0] WET_MAX   = 16'd32768;
	localparam logic [17:0] SR_MIN    = 18'd8000;
	localparam logic [16:0] RATE_BASE = 17'd44100;
	localparam logic [16:0] FB_DIV    = 17'd100;
	localparam logic [6:0]  FB_MUL    = 7'd84;
	localparam logic [5:0]  FB_HALF   = 6'd50;

	// reciprocals: floor(2^47 / 44100) and floor(2^32 / 100)
	localparam logic [31:0] RCP_RATE    = 32'd3191326266;
	localparam int          RCP_RATE_SH = 47;
	localparam logic [31:0] RCP_FB      = 32'd42949672;
	localparam int          RCP_FB_SH   = 32;

	typedef enum logic [1:0] {
		REG_ROOM = 2'd0,
		REG_DAMP = 2'd1,
		REG_WET  = 2'd2,
		REG_RATE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] room;
		logic [14:0] damp;
		logic [15:0] wet;
		logic [17:0] sr;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE     = 5'd0,
		OP_CLR      = 5'd1,
		OP_LOAD     = 5'd2,
		OP_AP_RD    = 5'd3,
		OP_AP_MUL1  = 5'd4,
		OP_AP_WR    = 5'd5,
		OP_AP_MUL2  = 5'd6,
		OP_AP_S     = 5'd7,
		OP_NET_RD   = 5'd8,
		OP_NET_MUL1 = 5'd9,
		OP_NET_MUL2 = 5'd10,
		OP_NET_LP   = 5'd11,
		OP_HAD      = 5'd12,
		OP_FB_MUL   = 5'd13,
		OP_NET_WR   = 5'd14,
		OP_MIX1     = 5'd15,
		OP_MIX2     = 5'd16,
		OP_MIX_OUT  = 5'd17
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [IDX_BITS-1:0] idx;
	} cmd_t;

endpackage

// ===== sv/allpass_fdn_reverb.sv =====
// top level of the allpass cascade and four line feedback delay network reverb
// one word in, one word out; each word is worked through by the step sequencer
// sharing one multiplier and one read port per delay memory across all stages and lines
// a new word is taken only once the previous word's result is in the output register
// reset or any register write clears both delay memories, one address per cycle over
// the larger depth (131072 addresses by default), during which no input word is taken
module allpass_fdn_reverb
	import afr_pkg::*;
#(
	parameter int AP_MAX_DELAY   = AP_MAX_DELAY_DEF,
	parameter int FDN_MAX_DELAY  = FDN_MAX_DELAY_DEF,
	parameter int ALLPASS_STAGES = ALLPASS_STAGES_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int AP_D  = ALLPASS_STAGES * AP_MAX_DELAY;
	localparam int NET_D = NET_LINES * FDN_MAX_DELAY;
	localparam int CLR_DEPTH = (AP_D > NET_D) ? AP_D : NET_D;
	localparam int CAW  = $clog2(CLR_DEPTH);
	localparam int APLW = $clog2(AP_MAX_DELAY + 1);
	localparam int NLW  = $clog2(FDN_MAX_DELAY + 1);

	cfg_t            cfg;
	logic            cfg_wr;
	logic            len_done;
	cmd_t            cmd;
	logic [CAW-1:0]  clr_addr;
	logic [APLW-1:0] ap_len [ALLPASS_STAGES];
	logic [NLW-1:0]  net_len [NET_LINES];
	logic [14:0]     fb;

	afr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	afr_len #(
		.AP_MAX_DELAY   (AP_MAX_DELAY),
		.FDN_MAX_DELAY  (FDN_MAX_DELAY),
		.ALLPASS_STAGES (ALLPASS_STAGES)
	) u_len (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_wr),
		.cfg     (cfg),
		.ap_len  (ap_len),
		.net_len (net_len),
		.fb      (fb),
		.done    (len_done)
	);

	afr_ctrl #(
		.ALLPASS_STAGES (ALLPASS_STAGES),
		.CLR_DEPTH      (CLR_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_wr    (cfg_wr),
		.len_done  (len_done),
		.cmd       (cmd),
		.clr_addr  (clr_addr)
	);

	afr_dp #(
		.AP_MAX_DELAY   (AP_MAX_DELAY),
		.FDN_MAX_DELAY  (FDN_MAX_DELAY),
		.ALLPASS_STAGES (ALLPASS_STAGES),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.CLR_DEPTH      (CLR_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.clr_addr   (clr_addr),
		.cfg        (cfg),
		.ap_len     (ap_len),
		.net_len    (net_len),
		.fb         (fb),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

// ===== sv/afr_ram.sv =====
// generic simple dual port ram with registered read
module afr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/afr_regs.sv =====
// apb configuration registers with clamped working values
module afr_regs
	import afr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg,
	output logic        cfg_wr
);

	logic [15:0] room_q;
	logic [14:0] damp_q;
	logic [15:0] wet_q;
	logic [17:0] sr_q;
	reg_idx_t    ridx;

	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q <= 16'd16384;
			damp_q <= 15'd16384;
			wet_q  <= 16'd9830;
			sr_q   <= 18'd44100;
		end else if (cfg_wr) begin
			case (ridx)
				REG_ROOM: room_q <= pwdata[15:0];
				REG_DAMP: damp_q <= pwdata[14:0];
				REG_WET:  wet_q  <= pwdata[15:0];
				REG_RATE: sr_q   <= pwdata[17:0];
				default:  room_q <= room_q;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_ROOM: prdata = {16'd0, room_q};
			REG_DAMP: prdata = {17'd0, damp_q};
			REG_WET:  prdata = {16'd0, wet_q};
			REG_RATE: prdata = {14'd0, sr_q};
			default:  prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.room = (room_q < ROOM_MIN) ? ROOM_MIN : ((room_q > ROOM_MAX) ? ROOM_MAX : room_q);
		cfg.damp = (damp_q > DAMP_MAX) ? DAMP_MAX : damp_q;
		cfg.wet  = (wet_q > WET_MAX) ? WET_MAX : wet_q;
		cfg.sr   = (sr_q < SR_MIN) ? SR_MIN : sr_q;
	end

endmodule

// ===== sv/afr_len.sv =====
// delay length and feedback gain calculation by reciprocal multiplication
module afr_len
	import afr_pkg::*;
#(
	parameter int AP_MAX_DELAY   = AP_MAX_DELAY_DEF,
	parameter int FDN_MAX_DELAY  = FDN_MAX_DELAY_DEF,
	parameter int ALLPASS_STAGES = ALLPASS_STAGES_DEF,
	localparam int APLW = $clog2(AP_MAX_DELAY + 1),
	localparam int NLW  = $clog2(FDN_MAX_DELAY + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cfg_t            cfg,
	output logic [APLW-1:0] ap_len [ALLPASS_STAGES],
	output logic [NLW-1:0]  net_len [NET_LINES],
	output logic [14:0]     fb,
	output logic            done
);

	localparam int NJ  = ALLPASS_STAGES + NET_LINES + 1;
	localparam int JW  = $clog2(NJ);
	localparam int AIW = (ALLPASS_STAGES > 1) ? $clog2(ALLPASS_STAGES) : 1;

	typedef enum logic [5:0] {
		LP_MUL1  = 6'b000001,
		LP_MUL2  = 6'b000010,
		LP_RCP   = 6'b000100,
		LP_CHK   = 6'b001000,
		LP_STORE = 6'b010000,
		LP_DONE  = 6'b100000
	} lphase_t;

	lphase_t         phase_q;
	logic [JW-1:0]   job_q;
	logic [28:0]     a_q;
	logic [31:0]     num_q;
	logic [16:0]     qt_q;
	logic [31:0]     rem_q;
	logic [APLW-1:0] ap_len_q [ALLPASS_STAGES];
	logic [NLW-1:0]  net_len_q [NET_LINES];
	logic [14:0]     fb_q;

	logic            is_ap, is_net, by_rate;
	logic [1:0]      nj;
	logic [AIW-1:0]  aj;
	logic [46:0]     prod;
	logic [31:0]     rcp;
	logic [63:0]     mprod;
	logic [16:0]     divisor, qt_c, qf;
	logic [31:0]     q;

	always_comb begin
		is_ap   = 32'(job_q) < ALLPASS_STAGES;
		is_net  = !is_ap && (32'(job_q) < ALLPASS_STAGES + NET_LINES);
		by_rate = is_ap || is_net;
		nj      = 2'(job_q - JW'(ALLPASS_STAGES));
		aj      = job_q[AIW-1:0];
		prod    = 47'(a_q * cfg.sr);
		divisor = by_rate ? RATE_BASE : FB_DIV;
		rcp     = by_rate ? RCP_RATE : RCP_FB;
		mprod   = 64'(num_q) * 64'(rcp);
		qt_c    = by_rate ? 17'(mprod >> RCP_RATE_SH) : 17'(mprod >> RCP_FB_SH);
		qf      = (rem_q >= 32'(divisor)) ? qt_q + 17'd1 : qt_q;
		q       = (qf == 17'd0) ? 32'd1 : 32'(qf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LP_MUL1;
			job_q   <= '0;
		end else if (start) begin
			phase_q <= LP_MUL1;
			job_q   <= '0;
		end else begin
			case (phase_q)
				LP_MUL1: phase_q <= LP_MUL2;
				LP_MUL2: phase_q <= LP_RCP;
				LP_RCP:  phase_q <= LP_CHK;
				LP_CHK:  phase_q <= LP_STORE;
				LP_STORE: begin
					if (32'(job_q) == NJ - 1) begin
						phase_q <= LP_DONE;
					end else begin
						job_q   <= job_q + 1'b1;
						phase_q <= LP_MUL1;
					end
				end
				LP_DONE: phase_q <= LP_DONE;
				default: phase_q <= LP_DONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			LP_MUL1: begin
				if (is_ap) begin
					a_q <= 29'(AP_TABLE[job_q[1:0]]);
				end else if (is_net) begin
					a_q <= 29'(NET_TABLE[nj] * cfg.room);
				end else begin
					a_q <= 29'(cfg.room * FB_MUL + FB_HALF);
				end
			end
			LP_MUL2: begin
				if (is_ap) begin
					num_q <= 32'(prod);
				end else if (is_net) begin
					num_q <= 32'(prod >> 15);
				end else begin
					num_q <= 32'(a_q);
				end
			end
			LP_RCP: qt_q <= qt_c;
			LP_CHK: rem_q <= num_q - 32'(qt_q * divisor);
			LP_STORE: begin
				if (is_ap) begin
					ap_len_q[aj] <= (q > 32'(AP_MAX_DELAY)) ? APLW'(AP_MAX_DELAY) : APLW'(q);
				end else if (is_net) begin
					net_len_q[nj] <= (q > 32'(FDN_MAX_DELAY)) ? NLW'(FDN_MAX_DELAY) : NLW'(q);
				end else begin
					fb_q <= 15'(qf);
				end
			end
			default: fb_q <= fb_q;
		endcase
	end

	assign ap_len  = ap_len_q;
	assign net_len = net_len_q;
	assign fb      = fb_q;
	assign done    = (phase_q == LP_DONE);

endmodule

// ===== sv/afr_ctrl.sv =====
// sequencer for clearing and per-word processing steps
module afr_ctrl
	import afr_pkg::*;
#(
	parameter int ALLPASS_STAGES = ALLPASS_STAGES_DEF,
	parameter int CLR_DEPTH      = 131072,
	localparam int CAW = $clog2(CLR_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           cfg_wr,
	input  logic           len_done,
	output cmd_t           cmd,
	output logic [CAW-1:0] clr_addr
);

	typedef enum logic [16:0] {
		ST_CLEAR    = 17'b00000000000000001,
		ST_IDLE     = 17'b00000000000000010,
		ST_AP_RD    = 17'b00000000000000100,
		ST_AP_MUL1  = 17'b00000000000001000,
		ST_AP_WR    = 17'b00000000000010000,
		ST_AP_MUL2  = 17'b00000000000100000,
		ST_AP_S     = 17'b00000000001000000,
		ST_NET_RD   = 17'b00000000010000000,
		ST_NET_MUL1 = 17'b00000000100000000,
		ST_NET_MUL2 = 17'b00000001000000000,
		ST_NET_LP   = 17'b00000010000000000,
		ST_HAD      = 17'b00000100000000000,
		ST_FB_MUL   = 17'b00001000000000000,
		ST_NET_WR   = 17'b00010000000000000,
		ST_MIX1     = 17'b00100000000000000,
		ST_MIX2     = 17'b01000000000000000,
		ST_MIX_OUT  = 17'b10000000000000000
	} state_t;

	state_t              state_q, state_d;
	logic [IDX_BITS-1:0] idx_q, idx_d;
	logic [CAW-1:0]      cnt_q;
	logic                clr_done_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd.op  = OP_NONE;
		cmd.idx = idx_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLR;
				if (clr_done_q && len_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					idx_d   = '0;
					state_d = ST_AP_RD;
				end
			end
			ST_AP_RD: begin
				cmd.op  = OP_AP_RD;
				state_d = ST_AP_MUL1;
			end
			ST_AP_MUL1: begin
				cmd.op  = OP_AP_MUL1;
				state_d = ST_AP_WR;
			end
			ST_AP_WR: begin
				cmd.op  = OP_AP_WR;
				state_d = ST_AP_MUL2;
			end
			ST_AP_MUL2: begin
				cmd.op  = OP_AP_MUL2;
				state_d = ST_AP_S;
			end
			ST_AP_S: begin
				cmd.op = OP_AP_S;
				if (32'(idx_q) == ALLPASS_STAGES - 1) begin
					idx_d   = '0;
					state_d = ST_NET_RD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_AP_RD;
				end
			end
			ST_NET_RD: begin
				cmd.op  = OP_NET_RD;
				state_d = ST_NET_MUL1;
			end
			ST_NET_MUL1: begin
				cmd.op  = OP_NET_MUL1;
				state_d = ST_NET_MUL2;
			end
			ST_NET_MUL2: begin
				cmd.op  = OP_NET_MUL2;
				state_d = ST_NET_LP;
			end
			ST_NET_LP: begin
				cmd.op = OP_NET_LP;
				if (32'(idx_q) == NET_LINES - 1) begin
					idx_d   = '0;
					state_d = ST_HAD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_NET_RD;
				end
			end
			ST_HAD: begin
				cmd.op  = OP_HAD;
				state_d = ST_FB_MUL;
			end
			ST_FB_MUL: begin
				cmd.op  = OP_FB_MUL;
				state_d = ST_NET_WR;
			end
			ST_NET_WR: begin
				cmd.op = OP_NET_WR;
				if (32'(idx_q) == NET_LINES - 1) begin
					idx_d   = '0;
					state_d = ST_MIX1;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_FB_MUL;
				end
			end
			ST_MIX1: begin
				cmd.op  = OP_MIX1;
				state_d = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.op  = OP_MIX2;
				state_d = ST_MIX_OUT;
			end
			ST_MIX_OUT: begin
				if (out_free) begin
					cmd.op  = OP_MIX_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_wr) begin
			state_d = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			cnt_q       <= '0;
			clr_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cfg_wr) begin
				cnt_q      <= '0;
				clr_done_q <= 1'b0;
			end else if (state_q == ST_CLEAR && !clr_done_q) begin
				if (cnt_q == CAW'(CLR_DEPTH - 1)) begin
					clr_done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.op == OP_MIX_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign clr_addr  = cnt_q;

endmodule

// ===== sv/afr_dp.sv =====
// datapath: delay memories, multiply and saturate unit, positions and filters
module afr_dp
	import afr_pkg::*;
#(
	parameter int AP_MAX_DELAY   = AP_MAX_DELAY_DEF,
	parameter int FDN_MAX_DELAY  = FDN_MAX_DELAY_DEF,
	parameter int ALLPASS_STAGES = ALLPASS_STAGES_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int CLR_DEPTH      = 131072,
	localparam int APLW = $clog2(AP_MAX_DELAY + 1),
	localparam int NLW  = $clog2(FDN_MAX_DELAY + 1),
	localparam int CAW  = $clog2(CLR_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  logic [CAW-1:0]                clr_addr,
	input  cfg_t                          cfg,
	input  logic [APLW-1:0]               ap_len [ALLPASS_STAGES],
	input  logic [NLW-1:0]                net_len [NET_LINES],
	input  logic [14:0]                   fb,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int SB     = SAMPLE_BITS;
	localparam int WW     = SB + 22;
	localparam int HW     = SB + 2;
	localparam int AP_D   = ALLPASS_STAGES * AP_MAX_DELAY;
	localparam int NET_D  = NET_LINES * FDN_MAX_DELAY;
	localparam int APAW   = $clog2(AP_D);
	localparam int NAW    = $clog2(NET_D);
	localparam int APW    = $clog2(AP_MAX_DELAY);
	localparam int NPW    = $clog2(FDN_MAX_DELAY);
	localparam int AIW    = (ALLPASS_STAGES > 1) ? $clog2(ALLPASS_STAGES) : 1;
	localparam logic signed [WW-1:0] SMAX = WW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [WW-1:0] SMIN = -SMAX - WW'(1);

	function automatic logic signed [SB-1:0] sat(input logic signed [WW-1:0] v);
		if (v > SMAX) begin
			return SB'(SMAX);
		end else if (v < SMIN) begin
			return SB'(SMIN);
		end
		return SB'(v);
	endfunction

	function automatic logic signed [WW-1:0] rnd(input logic signed [WW-1:0] v, input int s);
		logic signed [WW-1:0] h;
		h = WW'(1) <<< (s - 1);
		return (v + h) >>> s;
	endfunction

	logic signed [SB-1:0] x_q, s_q, dl_q, bi_q, out_q;
	logic signed [SB-1:0] rd_q [NET_LINES];
	logic signed [SB-1:0] ds_q [NET_LINES];
	logic signed [SB-1:0] lp_q [NET_LINES];
	logic signed [HW-1:0] hm_q [NET_LINES];
	logic signed [WW-1:0] prod_q, prod2_q;
	logic [APW-1:0]       ap_pos_q [ALLPASS_STAGES];
	logic [NPW-1:0]       net_pos_q [NET_LINES];

	logic [AIW-1:0]       ai;
	logic [1:0]           ni;
	logic signed [16:0]   gain, dcomp, dgain, wet, dry;
	logic signed [15:0]   fbs;
	logic [APLW-1:0]      ap_t;
	logic [NLW-1:0]       net_t;
	logic [APW-1:0]       ap_pos_nx;
	logic [NPW-1:0]       net_pos_nx;
	logic [APAW-1:0]      ap_addr;
	logic [NAW-1:0]       net_addr;
	logic                 ap_we, net_we;
	logic [APAW-1:0]      ap_waddr;
	logic [NAW-1:0]       net_waddr;
	logic signed [SB-1:0] ap_wdata, net_wdata, ap_rdata, net_rdata;
	logic signed [SB-1:0] bi_c, s_c, lp_c, v_c, res_c;
	logic signed [HW-1:0] sum_c;
	logic signed [HW-1:0] l0, l1, l2, l3;

	always_comb begin
		ai      = cmd.idx[AIW-1:0];
		ni      = cmd.idx[1:0];
		gain    = $signed({1'b0, GAIN_TABLE[cmd.idx]});
		dcomp   = $signed(17'(17'd32768 - {2'b00, cfg.damp}));
		dgain   = $signed({2'b00, cfg.damp});
		wet     = $signed({1'b0, cfg.wet});
		dry     = $signed(17'(17'd32768 - {1'b0, cfg.wet}));
		fbs     = $signed({1'b0, fb});
		ap_t    = APLW'(ap_pos_q[ai]) + 1'b1;
		net_t   = NLW'(net_pos_q[ni]) + 1'b1;
		ap_pos_nx  = (ap_t >= ap_len[ai]) ? '0 : APW'(ap_t);
		net_pos_nx = (net_t >= net_len[ni]) ? '0 : NPW'(net_t);
		ap_addr  = APAW'(APAW'(ai) * APAW'(AP_MAX_DELAY)) + APAW'(ap_pos_q[ai]);
		net_addr = NAW'(NAW'(ni) * NAW'(FDN_MAX_DELAY)) + NAW'(net_pos_q[ni]);
		bi_c  = sat(rnd(prod_q, 15) + WW'(s_q));
		s_c   = sat(WW'(dl_q) - rnd(prod_q, 15));
		lp_c  = sat(rnd(prod_q + prod2_q, 15));
		v_c   = sat(rnd(prod_q, 16) + WW'(s_q));
		res_c = sat(rnd(prod_q + prod2_q, 17));
		sum_c = HW'(rd_q[0]) + HW'(rd_q[1]) + HW'(rd_q[2]) + HW'(rd_q[3]);
		l0 = HW'(lp_q[0]);
		l1 = HW'(lp_q[1]);
		l2 = HW'(lp_q[2]);
		l3 = HW'(lp_q[3]);
		ap_we     = 1'b0;
		net_we    = 1'b0;
		ap_waddr  = ap_addr;
		net_waddr = net_addr;
		ap_wdata  = bi_c;
		net_wdata = v_c;
		if (cmd.op == OP_CLR) begin
			ap_we     = {1'b0, clr_addr} < (CAW + 1)'(AP_D);
			net_we    = {1'b0, clr_addr} < (CAW + 1)'(NET_D);
			ap_waddr  = clr_addr[APAW-1:0];
			net_waddr = clr_addr[NAW-1:0];
			ap_wdata  = '0;
			net_wdata = '0;
		end else if (cmd.op == OP_AP_WR) begin
			ap_we = 1'b1;
		end else if (cmd.op == OP_NET_WR) begin
			net_we = 1'b1;
		end
	end

	afr_ram #(.WIDTH(SB), .DEPTH(AP_D)) u_ap_ram (
		.clk   (clk),
		.we    (ap_we),
		.waddr (ap_waddr),
		.wdata (ap_wdata),
		.raddr (ap_addr),
		.rdata (ap_rdata)
	);

	afr_ram #(.WIDTH(SB), .DEPTH(NET_D)) u_net_ram (
		.clk   (clk),
		.we    (net_we),
		.waddr (net_waddr),
		.wdata (net_wdata),
		.raddr (net_addr),
		.rdata (net_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALLPASS_STAGES; i++) begin
				ap_pos_q[i] <= '0;
			end
			for (int i = 0; i < NET_LINES; i++) begin
				net_pos_q[i] <= '0;
				ds_q[i]      <= '0;
			end
		end else begin
			case (cmd.op)
				OP_CLR: begin
					for (int i = 0; i < ALLPASS_STAGES; i++) begin
						ap_pos_q[i] <= '0;
					end
					for (int i = 0; i < NET_LINES; i++) begin
						net_pos_q[i] <= '0;
						ds_q[i]      <= '0;
					end
				end
				OP_AP_S:   ap_pos_q[ai] <= ap_pos_nx;
				OP_NET_LP: ds_q[ni] <= lp_c;
				OP_NET_WR: net_pos_q[ni] <= net_pos_nx;
				default:   ds_q[0] <= ds_q[0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q <= sample_in;
				s_q <= sample_in;
			end
			OP_AP_MUL1: begin
				dl_q   <= ap_rdata;
				prod_q <= WW'(gain * ap_rdata);
			end
			OP_AP_WR:   bi_q <= bi_c;
			OP_AP_MUL2: prod_q <= WW'(gain * bi_q);
			OP_AP_S:    s_q <= s_c;
			OP_NET_MUL1: begin
				rd_q[ni] <= net_rdata;
				prod_q   <= WW'(dcomp * net_rdata);
			end
			OP_NET_MUL2: prod2_q <= WW'(dgain * ds_q[ni]);
			OP_NET_LP:   lp_q[ni] <= lp_c;
			OP_HAD: begin
				hm_q[0] <= (l0 + l1) + (l2 + l3);
				hm_q[1] <= (l0 - l1) + (l2 - l3);
				hm_q[2] <= (l0 + l1) - (l2 + l3);
				hm_q[3] <= (l0 - l1) - (l2 - l3);
			end
			OP_FB_MUL: prod_q <= WW'(fbs * hm_q[ni]);
			OP_MIX1:   prod_q <= WW'(dry * x_q) <<< 2;
			OP_MIX2:   prod2_q <= WW'(wet * sum_c);
			OP_MIX_OUT: out_q <= res_c;
			default:   out_q <= out_q;
		endcase
	end

	assign sample_out = out_q;

endmodule

// ===== sv/afr_checker.sv =====
// port level checks of the reverb top level and their bind
module afr_checker
	import afr_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic                   pready
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while busy");

	// register write starts a clearing pass
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=> !in_ready)
		else $error("input ready right after register write");

endmodule

bind allpass_fdn_reverb afr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_afr_checker (.*);
